// ===== hw/rtl/cms_pkg.sv =====
`default_nettype none
package cms_pkg;
    localparam int MAX_ROWS  = 8;
    localparam int MAX_WIDTH = 1024;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = MAX_ROWS * MAX_WIDTH;
    localparam int HR_W      = 4;
    localparam int RW_W      = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

    localparam logic FUNC_ADD = 1'b0;

    typedef struct packed {
        logic load;      // capture item, start hash
        logic hash_step; // one hash round
        logic row_start; // compute row hash, start modulo
        logic mod_step;  // one remainder bit
        logic rd;        // counter read step; never set, unused
        logic wb;        // write back / fold min
        logic row_next;
        logic done;
    } cms_cmd_t;

    typedef struct packed {
        logic hash_last;
        logic mod_last;
        logic row_last;
        logic clr_busy;  // counter RAM clearing pass running
    } cms_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
        rotl = (x << k) | (x >> (32 - k));
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/cms_ram.sv =====
`default_nettype none
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cms_datapath.sv =====
`default_nettype none
module cms_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cms_pkg::cms_cmd_t cmd,
    output cms_pkg::cms_sts_t      sts,
    input  wire logic              func,
    input  wire logic [63:0]       key,
    input  wire logic [3:0]        hash_rows,
    input  wire logic [10:0]       row_width,
    output logic [31:0]            result
);
    import cms_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] a_next, b_next, c_next;
    logic [2:0]  hstep_reg;
    logic        func_reg;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] last_row;
    logic [RW_W-1:0]  width;
    logic [31:0] h2m_reg;   // r * h2 accumulated
    logic [ADDR_W-1:0] base_reg;  // r * width, start of the current row
    logic [31:0] dvd_reg;
    logic [RW_W-1:0] rem_reg;
    logic [RW_W:0]   rem_sh;
    logic [4:0]  bit_reg;
    logic [31:0] best_reg;
    logic        clr_reg;
    logic [ADDR_W:0] clr_cnt_reg;
    logic        we;
    logic [ADDR_W-1:0] waddr, addr;
    logic [31:0] wdata, rdata, hrow;

    always_comb
    begin
        width = row_width;
        if (width == '0) width = RW_W'(1);
        if (width > RW_W'(MAX_WIDTH)) width = RW_W'(MAX_WIDTH);
        if (hash_rows == '0) last_row = '0;
        else if (hash_rows > HR_W'(MAX_ROWS)) last_row = ROW_W'(MAX_ROWS - 1);
        else last_row = ROW_W'(hash_rows - 4'd1);
    end

    // final mix, one round per cycle
    always_comb
    begin
        a_next = a_reg; b_next = b_reg; c_next = c_reg;
        case (hstep_reg)
            3'd0: c_next = (c_reg ^ b_reg) - rotl(b_reg, 14);
            3'd1: a_next = (a_reg ^ c_reg) - rotl(c_reg, 11);
            3'd2: b_next = (b_reg ^ a_reg) - rotl(a_reg, 25);
            3'd3: c_next = (c_reg ^ b_reg) - rotl(b_reg, 16);
            3'd4: a_next = (a_reg ^ c_reg) - rotl(c_reg, 4);
            3'd5: b_next = (b_reg ^ a_reg) - rotl(a_reg, 14);
            default: c_next = (c_reg ^ b_reg) - rotl(b_reg, 24);
        endcase
    end

    always_comb
    begin
        if (row_reg == '0) hrow = c_reg;
        else if (row_reg == ROW_W'(1)) hrow = b_reg;
        else hrow = c_reg + h2m_reg;
        rem_sh = {rem_reg, dvd_reg[31]};
    end

    // rows are packed at the configured width
    assign addr = base_reg + ADDR_W'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstep_reg   <= '0;
            row_reg     <= '0;
            bit_reg     <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (ADDR_W+1)'(DEPTH - 1)) clr_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                hstep_reg <= '0;
                row_reg   <= '0;
            end
            if (cmd.hash_step) hstep_reg <= hstep_reg + 3'd1;
            if (cmd.row_start) bit_reg <= '0;
            if (cmd.mod_step) bit_reg <= bit_reg + 5'd1;
            if (cmd.row_next) row_reg <= row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            a_reg    <= 32'hdeadbeef + 32'd8 + key[31:0];
            b_reg    <= 32'hdeadbeef + 32'd8 + key[63:32];
            c_reg    <= 32'hdeadbeef + 32'd8;
            h2m_reg  <= '0;
            base_reg <= '0;
            best_reg <= '1;
        end
        if (cmd.hash_step)
        begin
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        end
        if (cmd.row_start)
        begin
            dvd_reg <= hrow;
            rem_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (rem_sh >= {1'b0, width}) rem_reg <= RW_W'(rem_sh - {1'b0, width});
            else rem_reg <= rem_sh[RW_W-1:0];
        end
        if (cmd.wb && func_reg != FUNC_ADD && rdata < best_reg) best_reg <= rdata;
        if (cmd.row_next && row_reg != '0) h2m_reg <= h2m_reg + b_reg;
        else if (cmd.row_next) h2m_reg <= b_reg;
        if (cmd.row_next) base_reg <= base_reg + ADDR_W'(width);
    end

    always_comb
    begin
        if (clr_reg)
        begin
            we = 1'b1; waddr = clr_cnt_reg[ADDR_W-1:0]; wdata = '0;
        end
        else
        begin
            we = cmd.wb && func_reg == FUNC_ADD;
            waddr = addr; wdata = rdata + 32'd1;
        end
    end

    cms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(addr),
        .rdata(rdata)
    );

    assign result = (func_reg == FUNC_ADD) ? '0 : best_reg;
    assign sts.hash_last = (hstep_reg == 3'd6);
    assign sts.mod_last  = (bit_reg == 5'd31);
    assign sts.row_last  = (row_reg == last_row);
    assign sts.clr_busy  = clr_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/cms_ctrl.sv =====
`default_nettype none
module cms_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cms_pkg::cms_sts_t sts,
    output cms_pkg::cms_cmd_t      cmd
);
    import cms_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HASH = 7'b0000010,
        S_ROW  = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE) && !sts.clr_busy;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !sts.clr_busy)
                begin
                    cmd.load = 1'b1; state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) state_next = S_ROW;
            end
            S_ROW:
            begin
                cmd.row_start = 1'b1; state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) state_next = S_RD;
            end
            S_RD: state_next = S_WB;
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (sts.row_last) state_next = S_OUT;
                else
                begin
                    cmd.row_next = 1'b1; state_next = S_ROW;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.done = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/count_min_sketch.sv =====
`default_nettype none
// Count-min sketch over 8 rows of 1024 32-bit counters.
// Input channel in_valid/in_ready carries func (0 add, 1 estimate) and a
// 64-bit key. Output channel out_valid/out_ready carries estimate: the
// minimum counter over the rows in use, or zero for an add.
// Config: cfg_we writes cfg_index 0 (hash_rows) or 1 (row_width).
// Per item: a load step, 7 hash rounds, then per row a setup step,
// 32 remainder steps (one bit per cycle), a read and a write-back step,
// then the result waits in its own state. The bit-serial modulo and
// the single counter RAM set the time per item.
// One item is processed at a time; in_ready stays low from acceptance
// until the result is taken, so a stalled receiver holds the block.
// After reset a clearing pass zeroes all 8192 counters with in_ready
// low; configuration writes are taken meanwhile.
module count_min_sketch (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [63:0] key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      estimate,
    input  wire logic        cfg_we,
    input  wire logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cms_pkg::CFG_W-1:0]     cfg_data
);
    import cms_pkg::*;

    logic [HR_W-1:0] hash_rows_reg;
    logic [RW_W-1:0] row_width_reg;
    cms_cmd_t cmd;
    cms_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_rows_reg <= HR_W'(4);
            row_width_reg <= RW_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_ROWS: hash_rows_reg <= cfg_data[HR_W-1:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_data[RW_W-1:0];
                default: ;
            endcase
        end
    end

    cms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .sts(sts), .cmd(cmd)
    );

    cms_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .func(func), .key(key),
        .hash_rows(hash_rows_reg), .row_width(row_width_reg),
        .result(estimate)
    );
endmodule
`default_nettype wire
